@@ sv/sds_pkg.sv @@
// Shared types and constants for the sprite depth sorter.
// Depends on nothing; used by every module of the block.
package sds_pkg;

  localparam int MaxSprites = 16;
  localparam int PosW       = 15;
  localparam int SlotW      = 4;
  localparam int DistW      = 15;
  localparam int CntW       = $clog2(MaxSprites + 1);
  localparam int CountOutW  = 5;
  localparam int SqW        = 2 * PosW - 4;
  localparam int SumW       = SqW + 1;
  localparam int CfgIdxW    = 1;

  localparam logic [DistW-1:0]   DistMax    = {DistW{1'b1}};
  localparam logic [CfgIdxW-1:0] RegPlayerX = 1'b0;
  localparam logic [CfgIdxW-1:0] RegPlayerY = 1'b1;

  typedef struct packed {
    logic [DistW-1:0] depth;
    logic [SlotW-1:0] slot;
  } entry_t;

  typedef struct packed {
    logic   ins_en;
    logic   shift_up;
    entry_t ins;
  } cell_ctrl_t;

endpackage

@@ sv/sprite_depth_sorter.sv @@
// Top level: distance pipeline feeding a chain of insertion cells, plus emit control.
// Depends on sds_pkg, sds_dist, sds_cell.
//
//  channel   dir  transfer when          contents
//  s_axis    in   tvalid & tready        tdata: x[14:0] y[29:15] index[33:30]; tuser active
//  m_axis    out  tvalid & tready        tdata: index[3:0] dist[18:4] count[23:19]; tuser valid
//  cfg       in   cfg_we_i high          cfg_idx_i selects player_x / player_y
//
// One sprite per cycle while a group streams in; insertion into the chain is registered in the cells.
// A last sprite closes input until its group is out: it passes the distance pipeline,
// then one result per cycle (n results, or one for an empty group) as m_axis drains.
// m_axis stalls hold the chain. Reset clears counters and player position.
module sprite_depth_sorter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [39:0]                   s_axis_tdata,  // sprite_x, sprite_y, sprite_index, pad
  input  logic                          s_axis_tuser,  // sprite_active
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [23:0]                   m_axis_tdata,  // sorted_index, squared_distance, active_count
  output logic                          m_axis_tuser,  // entry_valid
  output logic                          m_axis_tlast,
  input  logic                          cfg_we_i,
  input  logic [sds_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sds_pkg::PosW-1:0]      cfg_wdata_i
);

  localparam int N = sds_pkg::MaxSprites;

  logic [sds_pkg::PosW-1:0] player_x_q, player_y_q;
  logic                     busy_q, emit_q;
  logic [sds_pkg::CntW-1:0] used_q, n_q, rem_q;
  logic                     in_xfer;
  logic                     p_vld, p_active, p_last;
  sds_pkg::entry_t          p_entry;
  logic                     full, ins_en, load, done;
  sds_pkg::cell_ctrl_t      ctrl;
  sds_pkg::entry_t          cell_q [N];
  logic [N-1:0]             keep;
  logic [N-1:0]             occ;

  logic                     out_vld_q, out_evld_q, out_last_q;
  logic [sds_pkg::SlotW-1:0]     out_slot_q;
  logic [sds_pkg::DistW-1:0]     out_dist_q;
  logic [sds_pkg::CountOutW-1:0] out_cnt_q;

  assign s_axis_tready = !busy_q;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      player_x_q <= '0;
      player_y_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sds_pkg::RegPlayerX: player_x_q <= cfg_wdata_i;
        sds_pkg::RegPlayerY: player_y_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  sds_dist u_dist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .vld_i      (in_xfer),
    .sx_i       (s_axis_tdata[14:0]),
    .sy_i       (s_axis_tdata[29:15]),
    .active_i   (s_axis_tuser),
    .slot_i     (s_axis_tdata[33:30]),
    .last_i     (s_axis_tlast),
    .player_x_i (player_x_q),
    .player_y_i (player_y_q),
    .vld_o      (p_vld),
    .active_o   (p_active),
    .last_o     (p_last),
    .entry_o    (p_entry)
  );

  assign full   = (used_q == sds_pkg::CntW'(N));
  assign ins_en = p_vld && p_active && !full;
  assign load   = emit_q && (!out_vld_q || m_axis_tready);
  assign done   = load && ((n_q == '0) || (rem_q == sds_pkg::CntW'(1)));

  assign ctrl.ins_en   = ins_en;
  assign ctrl.shift_up = load && (n_q != '0);
  assign ctrl.ins      = p_entry;

  for (genvar i = 0; i < N; i++) begin : g_cell
    assign occ[i] = (sds_pkg::CntW'(i) < used_q);
    sds_cell u_cell (
      .clk_i       (clk_i),
      .occ_i       (occ[i]),
      .prev_keep_i ((i == 0) ? 1'b1 : keep[(i == 0) ? 0 : i-1]),
      .prev_i      ((i == 0) ? sds_pkg::entry_t'('0) : cell_q[(i == 0) ? 0 : i-1]),
      .next_i      ((i == N-1) ? sds_pkg::entry_t'('0) : cell_q[(i == N-1) ? i : i+1]),
      .ctrl_i      (ctrl),
      .entry_o     (cell_q[i]),
      .keep_o      (keep[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      emit_q <= 1'b0;
      used_q <= '0;
      n_q    <= '0;
      rem_q  <= '0;
    end else begin
      if (in_xfer && s_axis_tlast) begin
        busy_q <= 1'b1;
      end
      if (ins_en) begin
        used_q <= used_q + sds_pkg::CntW'(1);
      end
      if (p_vld && p_last) begin
        emit_q <= 1'b1;
        n_q    <= used_q + sds_pkg::CntW'(ins_en);
        rem_q  <= used_q + sds_pkg::CntW'(ins_en);
      end
      if (load && (n_q != '0)) begin
        rem_q <= rem_q - sds_pkg::CntW'(1);
      end
      if (done) begin
        emit_q <= 1'b0;
        busy_q <= 1'b0;
        used_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_slot_q <= (n_q == '0) ? '0 : cell_q[0].slot;
      out_dist_q <= (n_q == '0) ? '0 : cell_q[0].depth;
      out_evld_q <= (n_q != '0);
      out_last_q <= done;
      out_cnt_q  <= sds_pkg::CountOutW'(n_q);
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_cnt_q, out_dist_q, out_slot_q};
  assign m_axis_tuser  = out_evld_q;
  assign m_axis_tlast  = out_last_q;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= sds_pkg::CntW'(N))
    else $error("store count beyond capacity");

  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_q |-> busy_q)
    else $error("emitting while input is open");

  a_no_ins_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_q |-> !ins_en)
    else $error("insert during emission");

  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tlast && m_axis_tdata[23:19] == '0))
    else $error("empty result must be alone");

endmodule

@@ sv/sds_dist.sv @@
// Three-stage squared distance pipeline: abs difference, square, sum and saturate.
// Depends on sds_pkg.
module sds_dist (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       vld_i,
  input  logic [sds_pkg::PosW-1:0]   sx_i,
  input  logic [sds_pkg::PosW-1:0]   sy_i,
  input  logic                       active_i,
  input  logic [sds_pkg::SlotW-1:0]  slot_i,
  input  logic                       last_i,
  input  logic [sds_pkg::PosW-1:0]   player_x_i,
  input  logic [sds_pkg::PosW-1:0]   player_y_i,
  output logic                       vld_o,
  output logic                       active_o,
  output logic                       last_o,
  output sds_pkg::entry_t            entry_o
);

  logic [2:0]                     vld_q;
  logic [2:0]                     active_q, last_q;
  logic [sds_pkg::SlotW-1:0]      slot_q [3];
  logic [sds_pkg::PosW-1:0]       dx_q, dy_q;
  logic [sds_pkg::PosW-1:0]       dx_d, dy_d;
  logic [2*sds_pkg::PosW-1:0]     sqx_full, sqy_full;
  logic [sds_pkg::SqW-1:0]        sqx_q, sqy_q;
  logic [sds_pkg::SumW-1:0]       sum;
  logic [sds_pkg::DistW-1:0]      dist_d, dist_q;

  assign dx_d = (sx_i >= player_x_i) ? sx_i - player_x_i : player_x_i - sx_i;
  assign dy_d = (sy_i >= player_y_i) ? sy_i - player_y_i : player_y_i - sy_i;
  assign sqx_full = dx_q * dx_q;
  assign sqy_full = dy_q * dy_q;
  assign sum = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign dist_d = (sum > sds_pkg::SumW'(sds_pkg::DistMax)) ? sds_pkg::DistMax
                                                           : sum[sds_pkg::DistW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    active_q  <= {active_q[1:0], active_i};
    last_q    <= {last_q[1:0], last_i};
    slot_q[0] <= slot_i;
    slot_q[1] <= slot_q[0];
    slot_q[2] <= slot_q[1];
    dx_q      <= dx_d;
    dy_q      <= dy_d;
    sqx_q     <= sqx_full[2*sds_pkg::PosW-1:4];
    sqy_q     <= sqy_full[2*sds_pkg::PosW-1:4];
    dist_q    <= dist_d;
  end

  assign vld_o         = vld_q[2];
  assign active_o      = active_q[2];
  assign last_o        = last_q[2];
  assign entry_o.depth = dist_q;
  assign entry_o.slot  = slot_q[2];

endmodule

@@ sv/sds_cell.sv @@
// One slot of the insertion chain: keeps, takes the new entry, or shifts.
// Depends on sds_pkg.
module sds_cell (
  input  logic                 clk_i,
  input  logic                 occ_i,
  input  logic                 prev_keep_i,
  input  sds_pkg::entry_t      prev_i,
  input  sds_pkg::entry_t      next_i,
  input  sds_pkg::cell_ctrl_t  ctrl_i,
  output sds_pkg::entry_t      entry_o,
  output logic                 keep_o
);

  sds_pkg::entry_t entry_q, entry_d;

  // ties stay ahead of the newcomer
  assign keep_o = occ_i && (entry_q.depth >= ctrl_i.ins.depth);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.shift_up) begin
      entry_d = next_i;
    end else if (ctrl_i.ins_en && !keep_o) begin
      entry_d = prev_keep_i ? ctrl_i.ins : prev_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule
